/* design/rtb_pkg.sv */
`default_nettype none
package rtb_pkg;

  localparam int NUM_CITIES = 64;
  localparam int NUM_ROUTES = 8;
  localparam int COST_BITS  = 16;
  localparam int CITY_W     = 6;
  localparam int ROUTE_W    = 3;
  localparam int POS_W      = 7;
  localparam int SLOT_AW    = ROUTE_W + CITY_W;
  localparam int DIST_AW    = 2 * CITY_W;
  localparam int SPARE_W    = 24;

  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_ROUTES   = 2'd1;
  localparam logic [1:0] CFG_PENALTY  = 2'd2;

  typedef enum logic [2:0] {
    REQ_WDIST  = 3'd0,
    REQ_WDEM   = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_MOVE   = 3'd3,
    REQ_SWAP   = 3'd4,
    REQ_REMOVE = 3'd5,
    REQ_EVAL   = 3'd6,
    REQ_BAD    = 3'd7
  } req_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_DECODE, OP_MAP_A, OP_MAP_B, OP_SH_RD, OP_SH_WR, OP_PLACE,
    OP_SW1, OP_SW2, OP_MAPRD, OP_RES_PLAIN, OP_RES_REJ, OP_RES_EDIT,
    OP_E_ROUTE, OP_E_TAB, OP_E_ACC, OP_E_RET, OP_E_LAST, OP_E_FIN
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_MAP_A, S_MAP_B, S_SH_CHK, S_SH_RD, S_SH_WR, S_PLACE,
    S_SW1, S_SW2, S_MAPRD, S_RES_PLAIN, S_RES_REJ, S_RES_EDIT,
    S_E_ROUTE, S_E_TAB, S_E_ACC, S_E_RET, S_E_LAST, S_E_FIN
  } state_t;

  typedef struct packed {
    op_t  op;
    logic take;
  } rtb_cmd_t;

  typedef struct packed {
    req_t rq;
    logic reject;
    logic shift_go;
    logic shift_more;
    logic route_empty;
    logic city_more;
    logic route_last;
    logic out_free;
  } rtb_stat_t;

  function automatic logic [SPARE_W-1:0] sat_spare(input logic [SPARE_W-1:0] s,
                                                   input logic [17:0] d);
    logic [SPARE_W:0] t;
    t = {s[SPARE_W-1], s} + {{(SPARE_W-17){d[17]}}, d};
    if (t[SPARE_W] != t[SPARE_W-1]) begin
      return t[SPARE_W] ? {1'b1, {(SPARE_W-1){1'b0}}} : {1'b0, {(SPARE_W-1){1'b1}}};
    end
    return t[SPARE_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* design/vehicle_route_table_engine.sv */
// channel  direction  handshake              payload
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// req      in         req_valid / req_ready  req_type .. table_value
// rsp      out        rsp_valid / rsp_ready  status .. last
//
// table writes and unknown requests: accept, decode, then the result word
// edits: decode, map lookups, a shift pass one slot at a time, place or swap writes, map read, result
// evaluate: per route, a table/accumulate pair per city in it, one slot-ram read each, then return leg and result
// synchronous reset clears route lengths and spare loads and sets config to defaults; no clear pass
// one request at a time; a stalled word holds in the output register
`default_nettype none
module vehicle_route_table_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [2:0]         req_type,
  input  logic [5:0]         city_a,
  input  logic [5:0]         city_b,
  input  logic [15:0]        load_a,
  input  logic [15:0]        load_b,
  input  logic [2:0]         route_sel,
  input  logic [6:0]         position,
  input  logic [15:0]        table_value,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic               status,
  output logic [2:0]         route_index,
  output logic [2:0]         city_route,
  output logic [5:0]         city_slot,
  output logic [22:0]        route_cost,
  output logic signed [23:0] spare_load,
  output logic [31:0]        total_cost,
  output logic               feasible,
  output logic               last
);
  import rtb_pkg::*;

  rtb_cmd_t  cmd;
  rtb_stat_t stat;

  assign cfg_ready = 1'b1;

  rtb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
    .stat(stat), .cmd(cmd)
  );

  rtb_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_type(req_type), .city_a(city_a), .city_b(city_b),
    .load_a(load_a), .load_b(load_b), .route_sel(route_sel),
    .position(position), .table_value(table_value),
    .rsp_ready(rsp_ready), .rsp_valid(rsp_valid), .status(status),
    .route_index(route_index), .city_route(city_route), .city_slot(city_slot),
    .route_cost(route_cost), .spare_load(spare_load), .total_cost(total_cost),
    .feasible(feasible), .last(last)
  );

`ifndef SYNTHESIS
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while busy");
  a_rej_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status) |-> last)
    else $error("rejected word not last");
  a_rej_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status) |-> (total_cost == 32'd0 && route_cost == 23'd0))
    else $error("rejected word carries cost");
`endif

endmodule
`default_nettype wire

/* design/rtb_ram.sv */
`default_nettype none
module rtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/rtb_ctrl.sv */
`default_nettype none
module rtb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  rtb_pkg::rtb_stat_t stat,
  output rtb_pkg::rtb_cmd_t  cmd
);
  import rtb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd.take   = 1'b0;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.take  = req_valid;
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.op = OP_DECODE;
        case (stat.rq)
          REQ_WDIST, REQ_WDEM: state_next = S_RES_PLAIN;
          REQ_INSERT: state_next = stat.reject ? S_MAPRD : S_SH_CHK;
          REQ_MOVE, REQ_SWAP, REQ_REMOVE: state_next = S_MAP_A;
          REQ_EVAL: state_next = S_E_ROUTE;
          default: state_next = S_RES_REJ;
        endcase
      end
      S_MAP_A: begin
        cmd.op = OP_MAP_A;
        if (stat.rq == REQ_SWAP) state_next = S_MAP_B;
        else if (stat.reject) state_next = S_MAPRD;
        else state_next = S_SH_CHK;
      end
      S_MAP_B: begin
        cmd.op     = OP_MAP_B;
        state_next = stat.reject ? S_MAPRD : S_SW1;
      end
      S_SW1: begin
        cmd.op     = OP_SW1;
        state_next = S_SW2;
      end
      S_SW2: begin
        cmd.op     = OP_SW2;
        state_next = S_MAPRD;
      end
      S_SH_CHK: begin
        if (stat.shift_go) state_next = S_SH_RD;
        else state_next = (stat.rq == REQ_REMOVE) ? S_MAPRD : S_PLACE;
      end
      S_SH_RD: begin
        cmd.op     = OP_SH_RD;
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.op = OP_SH_WR;
        if (!stat.shift_more) state_next = (stat.rq == REQ_REMOVE) ? S_MAPRD : S_PLACE;
      end
      S_PLACE: begin
        cmd.op     = OP_PLACE;
        state_next = S_MAPRD;
      end
      S_MAPRD: begin
        cmd.op     = OP_MAPRD;
        state_next = S_RES_EDIT;
      end
      S_RES_PLAIN: begin
        cmd.op = OP_RES_PLAIN;
        if (stat.out_free) state_next = S_IDLE;
      end
      S_RES_REJ: begin
        cmd.op = OP_RES_REJ;
        if (stat.out_free) state_next = S_IDLE;
      end
      S_RES_EDIT: begin
        cmd.op = OP_RES_EDIT;
        if (stat.out_free) state_next = S_IDLE;
      end
      S_E_ROUTE: begin
        cmd.op     = OP_E_ROUTE;
        state_next = stat.route_empty ? S_E_RET : S_E_TAB;
      end
      S_E_TAB: begin
        cmd.op     = OP_E_TAB;
        state_next = S_E_ACC;
      end
      S_E_ACC: begin
        cmd.op     = OP_E_ACC;
        state_next = stat.city_more ? S_E_TAB : S_E_RET;
      end
      S_E_RET: begin
        cmd.op     = OP_E_RET;
        state_next = S_E_LAST;
      end
      S_E_LAST: begin
        cmd.op     = OP_E_LAST;
        state_next = S_E_FIN;
      end
      S_E_FIN: begin
        cmd.op = OP_E_FIN;
        if (stat.out_free) state_next = stat.route_last ? S_IDLE : S_E_ROUTE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* design/rtb_datapath.sv */
`default_nettype none
module rtb_datapath (
  input  logic               clk,
  input  logic               rst,
  input  rtb_pkg::rtb_cmd_t  cmd,
  output rtb_pkg::rtb_stat_t stat,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic [2:0]         req_type,
  input  logic [5:0]         city_a,
  input  logic [5:0]         city_b,
  input  logic [15:0]        load_a,
  input  logic [15:0]        load_b,
  input  logic [2:0]         route_sel,
  input  logic [6:0]         position,
  input  logic [15:0]        table_value,
  input  logic               rsp_ready,
  output logic               rsp_valid,
  output logic               status,
  output logic [2:0]         route_index,
  output logic [2:0]         city_route,
  output logic [5:0]         city_slot,
  output logic [22:0]        route_cost,
  output logic signed [23:0] spare_load,
  output logic [31:0]        total_cost,
  output logic               feasible,
  output logic               last
);
  import rtb_pkg::*;

  logic [15:0] cap;
  logic [3:0]  rcount;
  logic [23:0] pen;

  req_t        rq;
  logic [5:0]  ca, cb;
  logic [15:0] la, lb;
  logic [2:0]  rsel;
  logic [6:0]  pos;
  logic [15:0] tval;

  logic [POS_W-1:0]   lengths [NUM_ROUTES];
  logic [SPARE_W-1:0] spare   [NUM_ROUTES];

  logic [2:0]  r, r2;
  logic [6:0]  p, lim, len, k;
  logic [5:0]  p2, prev;
  logic        dir_down, st, feas;
  logic [21:0] load;
  logic [23:0] cost;
  logic [31:0] total;

  logic               slot_we;
  logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
  logic [5:0]         slot_wdata, slot_rd;
  logic               rmap_we, smap_we;
  logic [5:0]         rmap_waddr, smap_waddr, map_raddr;
  logic [2:0]         rmap_wdata, rmap_rd;
  logic [5:0]         smap_wdata, smap_rd;
  logic               dem_we;
  logic [5:0]         dem_raddr;
  logic [15:0]        dem_rd;
  logic               dist_we;
  logic [DIST_AW-1:0] dist_raddr;
  logic [COST_BITS-1:0] dist_rd;

  logic [3:0]  rc;
  logic [2:0]  len_idx, spare_idx;
  logic [6:0]  len_rd, len_clamp, p_n, p_nn, kp1;
  logic [17:0] spare_delta;
  logic [SPARE_W-1:0] spare_new, spare_ev;
  logic        ins_rej, mv_rej, sw_rej, over, out_free, load_out;
  logic [23:0] pen_add;
  logic [33:0] sum;
  logic [31:0] total_sat;

  rtb_ram #(.WIDTH(6), .DEPTH(NUM_ROUTES * NUM_CITIES)) u_slots (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rd)
  );
  rtb_ram #(.WIDTH(3), .DEPTH(NUM_CITIES)) u_rmap (
    .clk(clk), .we(rmap_we), .waddr(rmap_waddr), .wdata(rmap_wdata),
    .raddr(map_raddr), .rdata(rmap_rd)
  );
  rtb_ram #(.WIDTH(6), .DEPTH(NUM_CITIES)) u_smap (
    .clk(clk), .we(smap_we), .waddr(smap_waddr), .wdata(smap_wdata),
    .raddr(map_raddr), .rdata(smap_rd)
  );
  rtb_ram #(.WIDTH(16), .DEPTH(NUM_CITIES)) u_dem (
    .clk(clk), .we(dem_we), .waddr(ca), .wdata(tval),
    .raddr(dem_raddr), .rdata(dem_rd)
  );
  rtb_ram #(.WIDTH(COST_BITS), .DEPTH(NUM_CITIES * NUM_CITIES)) u_dist (
    .clk(clk), .we(dist_we), .waddr({ca, cb}), .wdata(tval[COST_BITS-1:0]),
    .raddr(dist_raddr), .rdata(dist_rd)
  );

  assign rc = (rcount == 4'd0) ? 4'd1 :
              (rcount > 4'(NUM_ROUTES)) ? 4'(NUM_ROUTES) : rcount;
  assign p_n  = dir_down ? p - 7'd1 : p + 7'd1;
  assign p_nn = dir_down ? p_n - 7'd1 : p_n + 7'd1;
  assign kp1  = k + 7'd1;
  assign out_free = !rsp_valid || rsp_ready;

  always_comb begin
    len_idx     = r;
    spare_idx   = r;
    spare_delta = 18'd0;
    case (cmd.op)
      OP_DECODE: len_idx = rsel;
      OP_MAP_A: begin
        len_idx     = rmap_rd;
        spare_idx   = rmap_rd;
        spare_delta = {2'b00, la};
      end
      OP_MAP_B: len_idx = rmap_rd;
      OP_PLACE: spare_delta = 18'd0 - {2'b00, la};
      OP_SW1: spare_delta = {2'b00, la} - {2'b00, lb};
      OP_SW2: begin
        spare_idx   = r2;
        spare_delta = {2'b00, lb} - {2'b00, la};
      end
      default: ;
    endcase
  end

  assign len_rd    = lengths[len_idx];
  assign len_clamp = (len_rd > 7'(NUM_CITIES)) ? 7'(NUM_CITIES) : len_rd;
  assign spare_new = sat_spare(spare[spare_idx], spare_delta);

  assign ins_rej = ({1'b0, rsel} >= rc) || (pos > len_rd) || (len_rd >= 7'(NUM_CITIES));
  assign mv_rej  = ({1'b0, smap_rd} >= len_clamp) || ((rq == REQ_MOVE) && (pos > len_clamp));
  assign sw_rej  = {1'b0, smap_rd} >= len_rd;

  assign over      = load > {6'd0, cap};
  assign pen_add   = (over && feas) ? pen : 24'd0;
  assign sum       = {2'b00, total} + {10'd0, pen_add} + {10'd0, cost};
  assign total_sat = (sum[33:32] != 2'b00) ? 32'hffff_ffff : sum[31:0];
  assign spare_ev  = {8'd0, cap} - {2'b00, load};

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = {r, p[5:0]};
    slot_wdata = slot_rd;
    slot_raddr = {r, p_n[5:0]};
    rmap_we    = 1'b0;
    rmap_waddr = ca;
    rmap_wdata = r;
    smap_we    = 1'b0;
    smap_waddr = ca;
    smap_wdata = p[5:0];
    map_raddr  = ca;
    dem_we     = 1'b0;
    dem_raddr  = slot_rd;
    dist_we    = 1'b0;
    dist_raddr = {prev, slot_rd};
    case (cmd.op)
      OP_DECODE: begin
        dist_we = (rq == REQ_WDIST);
        dem_we  = (rq == REQ_WDEM);
      end
      OP_MAP_A: map_raddr = cb;
      OP_SH_WR: begin
        slot_we    = 1'b1;
        smap_we    = 1'b1;
        smap_waddr = slot_rd;
        slot_raddr = {r, p_nn[5:0]};
      end
      OP_PLACE: begin
        slot_we    = 1'b1;
        slot_wdata = ca;
        smap_we    = 1'b1;
        rmap_we    = (rq == REQ_INSERT);
      end
      OP_SW1: begin
        slot_we    = 1'b1;
        slot_waddr = {r2, p2};
        slot_wdata = ca;
        rmap_we    = 1'b1;
        rmap_waddr = cb;
        smap_we    = 1'b1;
        smap_waddr = cb;
      end
      OP_SW2: begin
        slot_we    = 1'b1;
        slot_wdata = cb;
        rmap_we    = 1'b1;
        rmap_wdata = r2;
        smap_we    = 1'b1;
        smap_wdata = p2;
      end
      OP_E_ROUTE: slot_raddr = {r, 6'd0};
      OP_E_ACC: slot_raddr = {r, kp1[5:0]};
      OP_E_RET: dist_raddr = {prev, 6'd0};
      default: ;
    endcase
  end

  always_comb begin
    stat.rq = rq;
    case (cmd.op)
      OP_DECODE: stat.reject = ins_rej;
      OP_MAP_A: stat.reject = (rq == REQ_SWAP) ? sw_rej : mv_rej;
      OP_MAP_B: stat.reject = st || sw_rej;
      default: stat.reject = st;
    endcase
    stat.shift_go    = dir_down ? (p > lim) : (p < lim);
    stat.shift_more  = dir_down ? (p_n > lim) : (p_n < lim);
    stat.route_empty = (len_rd == 7'd0);
    stat.city_more   = (kp1 < len);
    stat.route_last  = (({1'b0, r} + 4'd1) == rc);
    stat.out_free    = out_free;
  end

  assign load_out = out_free && ((cmd.op == OP_RES_PLAIN) || (cmd.op == OP_RES_REJ) ||
                                 (cmd.op == OP_RES_EDIT) || (cmd.op == OP_E_FIN));

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= 16'hffff;
      rcount    <= 4'd8;
      pen       <= 24'd100000;
      rsp_valid <= 1'b0;
      st        <= 1'b0;
      feas      <= 1'b1;
      dir_down  <= 1'b1;
      for (int i = 0; i < NUM_ROUTES; i++) begin
        lengths[i] <= '0;
        spare[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAPACITY: cap <= cfg_data[15:0];
          CFG_ROUTES: rcount <= cfg_data[3:0];
          CFG_PENALTY: pen <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.take) begin
        rq   <= req_t'(req_type);
        ca   <= city_a;
        cb   <= city_b;
        la   <= load_a;
        lb   <= load_b;
        rsel <= route_sel;
        pos  <= position;
        tval <= table_value;
      end
      case (cmd.op)
        OP_DECODE: begin
          r        <= (rq == REQ_EVAL) ? 3'd0 : rsel;
          p        <= len_rd;
          len      <= len_rd;
          lim      <= pos;
          dir_down <= 1'b1;
          st       <= (rq == REQ_INSERT) && ins_rej;
          total    <= 32'd0;
          feas     <= 1'b1;
        end
        OP_MAP_A: begin
          r   <= rmap_rd;
          p   <= {1'b0, smap_rd};
          len <= len_clamp;
          st  <= (rq == REQ_SWAP) ? sw_rej : mv_rej;
          if (rq == REQ_REMOVE) begin
            dir_down <= 1'b0;
            lim      <= len_clamp - 7'd1;
            if (!mv_rej) begin
              spare[rmap_rd]   <= spare_new;
              lengths[rmap_rd] <= len_clamp - 7'd1;
            end
          end else begin
            dir_down <= pos < {1'b0, smap_rd};
            if (pos < {1'b0, smap_rd}) lim <= pos;
            else lim <= (pos == 7'd0) ? 7'd0 : pos - 7'd1;
          end
        end
        OP_MAP_B: begin
          r2 <= rmap_rd;
          p2 <= smap_rd;
          st <= st || sw_rej;
        end
        OP_SH_WR: p <= p_n;
        OP_PLACE: begin
          if (rq == REQ_INSERT) begin
            lengths[r] <= len + 7'd1;
            spare[r]   <= spare_new;
          end
        end
        OP_SW1: if (r != r2) spare[r] <= spare_new;
        OP_SW2: if (r != r2) spare[r2] <= spare_new;
        OP_E_ROUTE: begin
          len  <= len_clamp;
          k    <= 7'd0;
          prev <= 6'd0;
          load <= 22'd0;
          cost <= 24'd0;
        end
        OP_E_TAB: prev <= slot_rd;
        OP_E_ACC: begin
          load <= load + 22'(dem_rd);
          cost <= cost + 24'(dist_rd);
          k    <= kp1;
        end
        OP_E_LAST: cost <= cost + 24'(dist_rd);
        OP_E_FIN: begin
          if (out_free) begin
            feas     <= feas && !over;
            total    <= total_sat;
            spare[r] <= spare_ev;
            r        <= r + 3'd1;
          end
        end
        default: ;
      endcase
      if (load_out) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= 1'b0;
      route_index <= 3'd0;
      city_route  <= 3'd0;
      city_slot   <= 6'd0;
      route_cost  <= 23'd0;
      spare_load  <= 24'sd0;
      total_cost  <= 32'd0;
      feasible    <= 1'b0;
      last        <= 1'b1;
      case (cmd.op)
        OP_RES_REJ: status <= 1'b1;
        OP_RES_EDIT: begin
          status     <= st;
          city_route <= rmap_rd;
          city_slot  <= smap_rd;
        end
        OP_E_FIN: begin
          route_index <= r;
          route_cost  <= cost[23] ? 23'h7fffff : cost[22:0];
          spare_load  <= $signed(spare_ev);
          total_cost  <= total_sat;
          feasible    <= feas && !over;
          last        <= stat.route_last;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* verif/tb_vehicle_route_table_engine.sv */
`default_nettype none
module tb_vehicle_route_table_engine;
  import rtb_pkg::*;

  typedef struct {
    req_t      kind;
    bit [5:0]  ca;
    bit [5:0]  cb;
    bit [15:0] la;
    bit [15:0] lb;
    bit [2:0]  rs;
    bit [6:0]  pos;
    bit [15:0] tv;
  } route_req_t;

  typedef struct packed {
    logic        st;
    logic [2:0]  ri;
    logic [2:0]  cr;
    logic [5:0]  cs;
    logic [22:0] rc;
    logic [23:0] sp;
    logic [31:0] tot;
    logic        fe;
    logic        la;
  } rsp_word_t;

  localparam int WATCHDOG_LIMIT = 6000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  logic [2:0] req_type = '0;
  logic [5:0] city_a = '0;
  logic [5:0] city_b = '0;
  logic [15:0] load_a = '0;
  logic [15:0] load_b = '0;
  logic [2:0] route_sel = '0;
  logic [6:0] position = '0;
  logic [15:0] table_value = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic status;
  logic [2:0] route_index;
  logic [2:0] city_route;
  logic [5:0] city_slot;
  logic [22:0] route_cost;
  logic signed [23:0] spare_load;
  logic [31:0] total_cost;
  logic feasible;
  logic last;

  vehicle_route_table_engine i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
    .city_a(city_a), .city_b(city_b), .load_a(load_a), .load_b(load_b),
    .route_sel(route_sel), .position(position), .table_value(table_value),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status),
    .route_index(route_index), .city_route(city_route), .city_slot(city_slot),
    .route_cost(route_cost), .spare_load(spare_load), .total_cost(total_cost),
    .feasible(feasible), .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mirrored solution state
  int        slots[8][64];
  int        route_len[8];
  int        map_r[64];
  int        map_s[64];
  longint    spare_v[8];
  int        dem_v[64];
  bit        dem_ok[64];
  int        dist_v[64][64];
  bit        dist_ok[64][64];
  bit        placed[64];
  longint    cap_reg = 65535;
  int        routes_reg = 8;
  longint    penalty_reg = 100000;

  rsp_word_t pending_words[$];
  int        fails = 0;
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;
  bit        hold_ack = 1'b0;
  int        hold_left = 0;
  int        idle_cycles = 0;

  route_req_t dir_req[$];
  bit         dir_typed[$];
  bit         dir_status[$];

  function automatic int live_routes();
    if (routes_reg == 0) return 1;
    if (routes_reg > 8) return 8;
    return routes_reg;
  endfunction

  function automatic longint clamp_spare(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic void model_request(route_req_t q, bit keep);
    rsp_word_t w;
    int r, p, len, tgt, c, rc, r1, r2, p1, p2, prev, cur;
    longint load, cost, total;
    bit feas;
    w = '0;
    w.la = 1'b1;
    case (q.kind)
      REQ_WDIST: begin
        dist_v[q.ca][q.cb] = q.tv;
        dist_ok[q.ca][q.cb] = 1'b1;
        if (keep) pending_words.push_back(w);
        return;
      end
      REQ_WDEM: begin
        dem_v[q.ca] = q.tv;
        dem_ok[q.ca] = 1'b1;
        if (keep) pending_words.push_back(w);
        return;
      end
      REQ_EVAL: begin
        rc = live_routes();
        total = 0;
        feas = 1'b1;
        for (r = 0; r < rc; r++) begin
          load = 0;
          cost = 0;
          prev = 0;
          len = route_len[r];
          for (int k = 0; k < len; k++) load += dem_v[slots[r][k]];
          spare_v[r] = clamp_spare(cap_reg - load);
          if (load > cap_reg && feas) begin
            feas = 1'b0;
            total += penalty_reg;
          end
          for (int k = 0; k < len; k++) begin
            cur = slots[r][k];
            cost += dist_v[prev][cur];
            prev = cur;
          end
          cost += dist_v[prev][0];
          total += cost;
          if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
          w = '0;
          w.ri = r;
          w.rc = (cost > 64'h7F_FFFF) ? 23'h7F_FFFF : cost[22:0];
          w.sp = spare_v[r][23:0];
          w.tot = total[31:0];
          w.fe = feas;
          w.la = (r == rc - 1);
          if (keep) pending_words.push_back(w);
        end
        return;
      end
      REQ_INSERT: begin
        len = route_len[q.rs];
        if (q.rs >= live_routes() || q.pos > len || len >= 64) begin
          w.st = 1'b1;
        end else begin
          r = q.rs;
          p = len;
          while (p > q.pos) begin
            c = slots[r][p-1];
            slots[r][p] = c;
            map_s[c] = p;
            p--;
          end
          slots[r][p] = q.ca;
          map_r[q.ca] = r;
          map_s[q.ca] = p;
          placed[q.ca] = 1'b1;
          route_len[r] = len + 1;
          spare_v[r] = clamp_spare(spare_v[r] - q.la);
        end
      end
      REQ_MOVE: begin
        r = map_r[q.ca];
        p = map_s[q.ca];
        len = route_len[r];
        if (p >= len || q.pos > len) begin
          w.st = 1'b1;
        end else if (q.pos < p) begin
          while (p > q.pos) begin
            c = slots[r][p-1];
            slots[r][p] = c;
            map_s[c] = p;
            p--;
          end
          slots[r][p] = q.ca;
          map_s[q.ca] = p;
        end else begin
          tgt = (q.pos == 0) ? 0 : q.pos - 1;
          while (p < tgt) begin
            c = slots[r][p+1];
            slots[r][p] = c;
            map_s[c] = p;
            p++;
          end
          slots[r][p] = q.ca;
          map_s[q.ca] = p;
        end
      end
      REQ_SWAP: begin
        r1 = map_r[q.ca];
        p1 = map_s[q.ca];
        r2 = map_r[q.cb];
        p2 = map_s[q.cb];
        if (p1 >= route_len[r1] || p2 >= route_len[r2]) begin
          w.st = 1'b1;
        end else begin
          slots[r2][p2] = q.ca;
          slots[r1][p1] = q.cb;
          map_r[q.cb] = r1;
          map_s[q.cb] = p1;
          map_r[q.ca] = r2;
          map_s[q.ca] = p2;
          if (r1 != r2) begin
            spare_v[r1] = clamp_spare(spare_v[r1] + q.la - q.lb);
            spare_v[r2] = clamp_spare(spare_v[r2] - q.la + q.lb);
          end
        end
      end
      REQ_REMOVE: begin
        r = map_r[q.ca];
        p = map_s[q.ca];
        len = route_len[r];
        if (p >= len) begin
          w.st = 1'b1;
        end else begin
          spare_v[r] = clamp_spare(spare_v[r] + q.la);
          route_len[r] = len - 1;
          while (p + 1 < len) begin
            c = slots[r][p+1];
            slots[r][p] = c;
            map_s[c] = p;
            p++;
          end
        end
      end
      default: begin
        w.st = 1'b1;
        if (keep) pending_words.push_back(w);
        return;
      end
    endcase
    w.cr = map_r[q.ca];
    w.cs = map_s[q.ca];
    if (keep) pending_words.push_back(w);
  endfunction

  // keeps every read inside entries that were written
  function automatic route_req_t shape_request(route_req_t q);
    int pool[$];
    int len;
    for (int c = 0; c < 64; c++) if (placed[c]) pool.push_back(c);
    if (pool.size() == 0 && q.kind inside {REQ_MOVE, REQ_SWAP, REQ_REMOVE}) begin
      q.kind = REQ_INSERT;
      q.rs = 0;
      q.pos = 0;
    end
    if (q.kind == REQ_INSERT) begin
      len = route_len[q.rs];
      if ((q.rs >= live_routes() || q.pos > len || len >= 64) && !placed[q.ca]) begin
        if (pool.size() > 0) q.ca = pool[$urandom_range(pool.size() - 1)];
        else begin
          q.rs = 0;
          q.pos = 0;
        end
      end
    end
    if (q.kind inside {REQ_MOVE, REQ_SWAP, REQ_REMOVE} && !placed[q.ca])
      q.ca = pool[$urandom_range(pool.size() - 1)];
    if (q.kind == REQ_SWAP && !placed[q.cb])
      q.cb = pool[$urandom_range(pool.size() - 1)];
    if (q.kind == REQ_MOVE && $urandom_range(4) != 0)
      q.pos = $urandom_range(route_len[map_r[q.ca]]);
    return q;
  endfunction

  function automatic route_req_t random_request();
    route_req_t q;
    int pick;
    pick = $urandom_range(99);
    q.ca = $urandom_range(63);
    q.cb = $urandom_range(63);
    q.la = $urandom_range(65535);
    q.lb = $urandom_range(65535);
    q.tv = $urandom_range(65535);
    q.rs = $urandom_range(7);
    q.pos = $urandom_range(127);
    if (pick < 35) begin
      q.kind = REQ_INSERT;
      if ($urandom_range(4) != 0) q.rs = $urandom_range(live_routes() - 1);
      if ($urandom_range(4) != 0) q.pos = $urandom_range(route_len[q.rs]);
    end else if (pick < 50) q.kind = REQ_MOVE;
    else if (pick < 62) q.kind = REQ_SWAP;
    else if (pick < 74) q.kind = REQ_REMOVE;
    else if (pick < 84) q.kind = REQ_EVAL;
    else if (pick < 90) q.kind = REQ_WDIST;
    else if (pick < 96) q.kind = REQ_WDEM;
    else q.kind = REQ_BAD;
    return q;
  endfunction

  task automatic send_word(route_req_t q, bit typed, bit typed_status);
    rsp_word_t w;
    req_valid   <= 1'b1;
    req_type    <= q.kind;
    city_a      <= q.ca;
    city_b      <= q.cb;
    load_a      <= q.la;
    load_b      <= q.lb;
    route_sel   <= q.rs;
    position    <= q.pos;
    table_value <= q.tv;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    model_request(q, !typed);
    if (typed) begin
      w = '0;
      w.st = typed_status;
      w.la = 1'b1;
      pending_words.push_back(w);
    end
    if (!calm && $urandom_range(99) < 38) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 38) @(posedge clk);
    end
  endtask

  task automatic fill_eval_reads();
    route_req_t w;
    int prev, cur;
    w.lb = 0;
    w.la = 0;
    w.rs = 0;
    w.pos = 0;
    for (int r = 0; r < live_routes(); r++) begin
      prev = 0;
      for (int k = 0; k <= route_len[r]; k++) begin
        cur = (k == route_len[r]) ? 0 : slots[r][k];
        if (!dem_ok[cur]) begin
          w.kind = REQ_WDEM;
          w.ca = cur;
          w.cb = 0;
          w.tv = $urandom_range(65535);
          send_word(w, 1'b0, 1'b0);
        end
        if (!dist_ok[prev][cur]) begin
          w.kind = REQ_WDIST;
          w.ca = prev;
          w.cb = cur;
          w.tv = $urandom_range(65535);
          send_word(w, 1'b0, 1'b0);
        end
        prev = cur;
      end
    end
  endtask

  task automatic run_request(route_req_t q, bit typed, bit typed_status);
    if (q.kind == REQ_EVAL) fill_eval_reads();
    send_word(q, typed, typed_status);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CAPACITY: cap_reg = val[15:0];
      CFG_ROUTES:   routes_reg = val[3:0];
      CFG_PENALTY:  penalty_reg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic add_row(req_t k, int ca, int cb, int la, int lb, int rs, int pos,
                         int tv, bit typed, bit st);
    route_req_t q;
    q.kind = k;
    q.ca = ca;
    q.cb = cb;
    q.la = la;
    q.lb = lb;
    q.rs = rs;
    q.pos = pos;
    q.tv = tv;
    dir_req.push_back(q);
    dir_typed.push_back(typed);
    dir_status.push_back(st);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= calm || ($urandom_range(99) >= 38);
      end
      if (rsp_valid && rsp_ready) begin
        if (pending_words.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result word: status %0d route %0d", status,
                                    route_index);
        end else begin
          rsp_word_t want, got;
          want = pending_words.pop_front();
          got = {status, route_index, city_route, city_slot, route_cost, spare_load,
                 total_cost, feasible, last};
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("result mismatch: exp st %0d ri %0d cr %0d cs %0d cost %0d spare %0d tot %0d fe %0d last %0d / got st %0d ri %0d cr %0d cs %0d cost %0d spare %0d tot %0d fe %0d last %0d",
                       want.st, want.ri, want.cr, want.cs, want.rc, $signed(want.sp), want.tot,
                       want.fe, want.la, got.st, got.ri, got.cr, got.cs, got.rc,
                       $signed(got.sp), got.tot, got.fe, got.la);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_vehicle_route_table_engine NOT OK");
      $finish;
    end
  end

  initial begin
    route_req_t q;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(REQ_WDIST, 0, 0, 0, 0, 0, 0, 0, 1, 0);
    add_row(REQ_WDIST, 63, 63, 65535, 65535, 7, 127, 65535, 1, 0);
    add_row(REQ_WDEM, 63, 0, 0, 0, 0, 0, 65535, 1, 0);
    add_row(REQ_WDEM, 0, 63, 0, 0, 0, 0, 0, 1, 0);
    add_row(REQ_BAD, 63, 63, 65535, 65535, 7, 127, 65535, 1, 1);
    add_row(REQ_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(REQ_INSERT, 5, 0, 100, 0, 0, 0, 0, 0, 0);
    add_row(REQ_INSERT, 63, 0, 65535, 0, 7, 0, 0, 0, 0);
    add_row(REQ_INSERT, 12, 0, 7, 0, 0, 0, 0, 0, 0);
    add_row(REQ_INSERT, 20, 0, 3000, 0, 0, 2, 0, 0, 0);
    add_row(REQ_INSERT, 5, 0, 1, 0, 0, 127, 0, 0, 0);
    add_row(REQ_INSERT, 5, 0, 50, 0, 3, 0, 0, 0, 0);
    add_row(REQ_MOVE, 20, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(REQ_MOVE, 20, 0, 0, 0, 0, 3, 0, 0, 0);
    add_row(REQ_MOVE, 12, 0, 0, 0, 0, 1, 0, 0, 0);
    add_row(REQ_MOVE, 12, 0, 0, 0, 0, 64, 0, 0, 0);
    add_row(REQ_SWAP, 63, 20, 65535, 3000, 0, 0, 0, 0, 0);
    add_row(REQ_SWAP, 12, 12, 9, 9, 0, 0, 0, 0, 0);
    add_row(REQ_REMOVE, 63, 0, 65535, 0, 0, 0, 0, 0, 0);
    add_row(REQ_REMOVE, 63, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(REQ_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(REQ_INSERT, 1, 0, 0, 0, 6, 0, 0, 0, 0);
    add_row(REQ_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    foreach (dir_req[i]) run_request(dir_req[i], dir_typed[i], dir_status[i]);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          write_reg(CFG_CAPACITY, 24'd0);
          write_reg(CFG_ROUTES, 24'd1);
          write_reg(CFG_PENALTY, 24'd0);
        end
        1: begin
          write_reg(CFG_CAPACITY, 24'd65535);
          write_reg(CFG_ROUTES, 24'd8);
          write_reg(CFG_PENALTY, 24'hFF_FFFF);
        end
        2: begin
          write_reg(CFG_CAPACITY, $urandom_range(65535));
          write_reg(CFG_ROUTES, $urandom_range(1, 8));
          write_reg(CFG_PENALTY, $urandom_range(24'hFF_FFFF));
        end
        default: begin
          write_reg(CFG_CAPACITY, $urandom_range(20000, 65535));
          write_reg(CFG_ROUTES, $urandom_range(2, 5));
          write_reg(CFG_PENALTY, 24'd100000);
        end
      endcase
      calm = (ph == 2);
      for (int n = 0; n < 8; n++) run_request(shape_request(random_request()), 1'b0, 1'b0);
      if (ph == 1) begin
        // load one route while the output side is held off
        hold_req = !hold_req;
        for (int n = 0; n < 10; n++) begin
          q = random_request();
          q.kind = REQ_INSERT;
          q.rs = 1;
          q.pos = $urandom_range(route_len[1]);
          run_request(shape_request(q), 1'b0, 1'b0);
        end
        q.kind = REQ_EVAL;
        run_request(q, 1'b0, 1'b0);
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (100) @(posedge clk);
    if (fails == 0 && pending_words.size() == 0) begin
      $display("tb_vehicle_route_table_engine OK");
    end else begin
      $display("tb_vehicle_route_table_engine NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
design/rtb_pkg.sv
design/rtb_ram.sv
design/rtb_ctrl.sv
design/rtb_datapath.sv
design/vehicle_route_table_engine.sv
verif/tb_vehicle_route_table_engine.sv
